[rtl/core/dhwm_pkg.sv]
`default_nettype none

package dhwm_pkg;

	// table size limits
	localparam int unsigned DEFAULT_TABLE_DEPTH = 64;
	localparam int unsigned MAX_TABLE_DEPTH     = 64;

	// fixed field widths
	localparam int unsigned LAYER_W     = 8;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned POS_W       = 16;
	localparam int unsigned ENERGY_W    = 32;
	localparam int unsigned KIND_W      = 3;
	localparam int unsigned ENTRY_IDX_W = 6;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_WINDOW  = 2'd1;

	localparam logic [TIME_W-1:0] TIME_WINDOW_RESET = 32'd5000;
	localparam logic [POS_W-1:0]  POS_WINDOW_RESET  = 16'd200;

	// input opcodes
	localparam logic OP_DEPOSIT = 1'b0;
	localparam logic OP_END     = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_MERGED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NEW    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd4;

	typedef struct packed {
		logic                       opcode;
		logic [LAYER_W-1:0]         layer;
		logic [TIME_W-1:0]          step_time;
		logic signed [POS_W-1:0]    step_x;
		logic signed [POS_W-1:0]    step_z;
		logic [ENERGY_W-1:0]        energy_ev;
	} in_word_t;

	typedef struct packed {
		logic [KIND_W-1:0]          result_kind;
		logic [ENTRY_IDX_W-1:0]     entry_index;
		logic [LAYER_W-1:0]         hit_layer;
		logic [TIME_W-1:0]          hit_time;
		logic signed [POS_W-1:0]    hit_x;
		logic signed [POS_W-1:0]    hit_z;
		logic [ENERGY_W-1:0]        hit_energy;
		logic                       last;
	} out_word_t;

	// one stored hit
	typedef struct packed {
		logic [LAYER_W-1:0]         layer;
		logic [TIME_W-1:0]          tstamp;
		logic [POS_W-1:0]           x;
		logic [POS_W-1:0]           z;
		logic [ENERGY_W-1:0]        energy;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MERGE,
		S_APPEND,
		S_EMPTY,
		S_DUMP_RD,
		S_DUMP_WR
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic scan_step;
		logic merge_load;
		logic append_load;
		logic drop_load;
		logic empty_load;
		logic dump_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_end;
		logic cnt_zero;
		logic scan_hit;
		logic scan_done;
		logic table_full;
		logic dump_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[rtl/core/detector_hit_window_merger.sv]
// Detector hit window merger: folds deposit steps into a table of hits.
// Channels (valid/ready, a word moves when both are high):
//   in_*  : one deposit or end-of-event word; opcode 0 deposits, 1 ends the event.
//   out_* : result words; last marks the final word caused by one input word.
//   cfg_* : register writes, index 0 time window, 1 position window; always ready.
// A deposit walks the stored hits one per cycle through the table's registered
// read port, lowest index first: scan, then a merge (saturating energy, earliest
// time) or append, or a drop if full; its single result sits in the output
// register. End of event emits every stored hit, by a read state then a load
// state for each, and empties the table; an empty table gives one
// "empty event" word.
// Only one word is in work at a time; in_ready is high when the controller idles,
// even while a finished result still waits in the output register.
// If the receiver stalls, the output word holds and the controller waits before
// loading the next one; the table is never overwritten by a pending result.
// Reset (arst_n low) empties the table by clearing the fill count, restores the
// window registers to 5000 ps and 200 mm, and drops any pending output word.
`default_nettype none

module detector_hit_window_merger import dhwm_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_word,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_word,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_value
);

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t status;

	dhwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	dhwm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_value (cfg_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

[rtl/core/dhwm_ctrl.sv]
`default_nettype none

module dhwm_ctrl import dhwm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.in_end) begin
						state_d = status.cnt_zero ? S_EMPTY : S_DUMP_RD;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_hit) begin
					state_d = S_MERGE;
				end else if (status.scan_done) begin
					state_d = S_APPEND;
				end
			end
			S_MERGE: begin
				if (status.out_free) begin
					cmd.merge_load = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_APPEND: begin
				if (status.out_free) begin
					cmd.drop_load   = status.table_full;
					cmd.append_load = !status.table_full;
					state_d         = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (status.out_free) begin
					cmd.empty_load = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				// read data lands in the register next cycle
				state_d = S_DUMP_WR;
			end
			S_DUMP_WR: begin
				if (status.out_free) begin
					cmd.dump_load = 1'b1;
					state_d       = status.dump_last ? S_IDLE : S_DUMP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("accepted word did not start processing");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.merge_load, cmd.append_load, cmd.drop_load,
			cmd.empty_load, cmd.dump_load}) <= 1)
		else $error("more than one result load in a cycle");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.merge_load || cmd.append_load || cmd.drop_load || cmd.empty_load ||
			cmd.dump_load) |-> status.out_free)
		else $error("result loaded while output register busy");
`endif

endmodule

`default_nettype wire

[rtl/core/dhwm_datapath.sv]
`default_nettype none

module dhwm_datapath import dhwm_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire in_word_t              in_word,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_word,
	input  wire cmd_t                  cmd,
	output status_t                    status
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_DEPTH);

	// configuration
	logic [TIME_W-1:0] time_win_q;
	logic [POS_W-1:0]  pos_win_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_win_q <= TIME_WINDOW_RESET;
			pos_win_q  <= POS_WINDOW_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TIME_WINDOW) begin
				time_win_q <= cfg_value[TIME_W-1:0];
			end
			if (cfg_index == CFG_POS_WINDOW) begin
				pos_win_q <= cfg_value[POS_W-1:0];
			end
		end
	end

	// held item
	in_word_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_word;
		end
	end

	// fill count and walk pointer
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] ptr_inc;
	logic             ptr_live;

	assign ptr_inc  = ptr_q + CNT_W'(1);
	assign ptr_live = ptr_q < cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.append_load) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.dump_load && status.dump_last) begin
				cnt_q <= '0;
			end
			if (cmd.capture) begin
				ptr_q <= '0;
			end else if ((cmd.scan_step && ptr_live) || cmd.dump_load) begin
				ptr_q <= ptr_inc;
			end
		end
	end

	// hit table, one write and one registered read port
	entry_t           tbl_q [TABLE_DEPTH];
	entry_t           rd_data_s1;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	assign rd_addr = ptr_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= tbl_q[rd_addr];
	end

	// compare stage
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_step && ptr_live;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr;
	end

	logic [TIME_W-1:0] dt;
	logic [POS_W:0]    dx, dz, adx, adz;
	logic              match;

	always_comb begin
		dt = (item_q.step_time > rd_data_s1.tstamp) ?
			item_q.step_time - rd_data_s1.tstamp :
			rd_data_s1.tstamp - item_q.step_time;
		dx  = {item_q.step_x[POS_W-1], item_q.step_x} -
			{rd_data_s1.x[POS_W-1], rd_data_s1.x};
		dz  = {item_q.step_z[POS_W-1], item_q.step_z} -
			{rd_data_s1.z[POS_W-1], rd_data_s1.z};
		adx = dx[POS_W] ? -dx : dx;
		adz = dz[POS_W] ? -dz : dz;
		match = cmp_vld_s1 && (rd_data_s1.layer == item_q.layer) &&
			(dt <= time_win_q) &&
			(adx <= {1'b0, pos_win_q}) && (adz <= {1'b0, pos_win_q});
	end

	// matched entry
	entry_t           hit_q;
	logic [IDX_W-1:0] hit_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.scan_step && match) begin
			hit_q     <= rd_data_s1;
			hit_idx_q <= cmp_idx_s1;
		end
	end

	// merge arithmetic
	logic [ENERGY_W:0] esum;
	entry_t            merged;
	entry_t            fresh;

	always_comb begin
		esum          = {1'b0, hit_q.energy} + {1'b0, item_q.energy_ev};
		merged        = hit_q;
		merged.energy = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
		if (item_q.step_time < hit_q.tstamp) begin
			merged.tstamp = item_q.step_time;
		end
		fresh.layer  = item_q.layer;
		fresh.tstamp = item_q.step_time;
		fresh.x      = item_q.step_x;
		fresh.z      = item_q.step_z;
		fresh.energy = item_q.energy_ev;
	end

	assign wr_en   = cmd.merge_load || cmd.append_load;
	assign wr_addr = cmd.merge_load ? hit_idx_q : cnt_q[IDX_W-1:0];
	assign wr_data = cmd.merge_load ? merged : fresh;

	// output register
	logic      out_vld_q;
	out_word_t out_q;
	out_word_t out_d;
	logic      out_load;

	function automatic out_word_t fill(input logic [KIND_W-1:0] kind,
		input logic [IDX_W-1:0] idx, input entry_t e, input logic lst);
		out_word_t w;
		w.result_kind = kind;
		w.entry_index = ENTRY_IDX_W'(idx);
		w.hit_layer   = e.layer;
		w.hit_time    = e.tstamp;
		w.hit_x       = e.x;
		w.hit_z       = e.z;
		w.hit_energy  = e.energy;
		w.last        = lst;
		return w;
	endfunction

	assign out_load = cmd.merge_load || cmd.append_load || cmd.drop_load ||
		cmd.empty_load || cmd.dump_load;

	always_comb begin
		priority if (cmd.merge_load) begin
			out_d = fill(KIND_MERGED, hit_idx_q, merged, 1'b1);
		end else if (cmd.append_load) begin
			out_d = fill(KIND_NEW, cnt_q[IDX_W-1:0], fresh, 1'b1);
		end else if (cmd.dump_load) begin
			out_d = fill(KIND_DUMP, ptr_q[IDX_W-1:0], rd_data_s1, status.dump_last);
		end else if (cmd.drop_load) begin
			out_d = fill(KIND_FULL, '0, '0, 1'b1);
		end else begin
			out_d = fill(KIND_EMPTY, '0, '0, 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = out_q;

	// status
	assign status.in_end     = (in_word.opcode == OP_END);
	assign status.cnt_zero   = (cnt_q == '0);
	assign status.scan_hit   = match;
	assign status.scan_done  = !cmp_vld_s1 && (ptr_q == cnt_q);
	assign status.table_full = (cnt_q == CNT_MAX);
	assign status.dump_last  = (ptr_inc == cnt_q);
	assign status.out_free   = !out_vld_q || out_ready;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("fill count beyond table depth");

	a_dump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dump_load && status.dump_last) |=> (cnt_q == '0))
		else $error("table not emptied after final dump");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append_load |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("append did not grow the table");
`endif

endmodule

`default_nettype wire
